/* rtl/sorted_table_lower_bound_macros.svh */
// Assertion macros for the sorted table lower-bound search block.
`ifndef SORTED_TABLE_LOWER_BOUND_MACROS_SVH
`define SORTED_TABLE_LOWER_BOUND_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define STLB_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define STLB_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* rtl/stlb_pkg.sv */
// Shared constants and types for the sorted table lower-bound search block.
package stlb_pkg;

    localparam int COUNT_W         = 11;
    localparam int INDEX_W         = 10;
    localparam int KEY_IN_W        = 32;
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_KEY_WIDTH   = 32;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [INDEX_W-1:0]  entry_index;
        logic [KEY_IN_W-1:0] key_value;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] position;
        logic               found;
    } rsp_t;

endpackage

/* rtl/stlb_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module stlb_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/stlb_seq.sv */
// Search sequencer: count register, halving probe loop, result register.
`include "sorted_table_lower_bound_macros.svh"

module stlb_seq
    import stlb_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [COUNT_W-1:0]             cfg_wr_data,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  req_t                           req,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output rsp_t                           rsp,
    output logic                           ram_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_wr_addr,
    output logic [KEY_WIDTH-1:0]           ram_wr_data,
    output logic                           ram_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] ram_rd_addr,
    input  logic [KEY_WIDTH-1:0]           ram_rd_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_VERIFY = 4'b0100,
        S_HOLD   = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [COUNT_W-1:0] lo_reg, lo_next;
    logic [COUNT_W-1:0] hi_reg, hi_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [COUNT_W-1:0] pos_reg, pos_next;
    logic               hit_reg, hit_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    logic               req_accept;
    logic [COUNT_W-1:0] eff_count;
    logic               less;
    logic [COUNT_W-1:0] mid_cur;
    logic [COUNT_W-1:0] lo_probe, hi_probe, mid_calc, mid_first;

    assign req_stall  = (state_reg != S_IDLE);
    assign req_accept = req_valid && !req_stall;
    assign rsp_valid  = rsp_valid_reg;
    assign rsp        = rsp_reg;

    assign eff_count = (32'(count_reg) > 32'(TABLE_DEPTH)) ? COUNT_W'(TABLE_DEPTH) : count_reg;

    // shared compare and halving unit
    assign mid_cur   = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign less      = ram_rd_data < key_reg;
    assign lo_probe  = less ? mid_cur + COUNT_W'(1) : lo_reg;
    assign hi_probe  = less ? hi_reg : mid_cur;
    assign mid_calc  = lo_probe + ((hi_probe - lo_probe) >> 1);
    assign mid_first = eff_count >> 1;

    assign ram_wr_addr = ADDR_W'(req.entry_index);
    assign ram_wr_data = KEY_WIDTH'(req.key_value);

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        key_next       = key_reg;
        pos_next       = pos_reg;
        hit_next       = hit_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = ADDR_W'(mid_calc);

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_accept)
                begin
                    if (req.kind == KIND_LOAD)
                    begin
                        ram_wr_en = (32'(req.entry_index) < 32'(TABLE_DEPTH));
                    end
                    else
                    begin
                        key_next = KEY_WIDTH'(req.key_value);
                        n_next   = eff_count;
                        if (eff_count == '0)
                        begin
                            pos_next   = '0;
                            hit_next   = 1'b0;
                            state_next = S_HOLD;
                        end
                        else
                        begin
                            lo_next     = '0;
                            hi_next     = eff_count;
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = ADDR_W'(mid_first);
                            state_next  = S_SEARCH;
                        end
                    end
                end
            end
            S_SEARCH:
            begin
                // ram_rd_data holds the key at the mid of the current lo/hi range
                lo_next = lo_probe;
                hi_next = hi_probe;
                if (lo_probe < hi_probe)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ADDR_W'(mid_calc);
                end
                else if (lo_probe < n_reg)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = ADDR_W'(lo_probe);
                    state_next  = S_VERIFY;
                end
                else
                begin
                    pos_next   = lo_probe;
                    hit_next   = 1'b0;
                    state_next = S_HOLD;
                end
            end
            S_VERIFY:
            begin
                pos_next   = lo_reg;
                hit_next   = (ram_rd_data == key_reg);
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.position = pos_reg;
                    rsp_next.found    = hit_reg;
                    rsp_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        key_reg <= key_next;
        pos_reg <= pos_next;
        hit_reg <= hit_next;
        rsp_reg <= rsp_next;
    end

    `STLB_ASSERT_NOW(a_search_range, state_reg == S_SEARCH, lo_reg < hi_reg, "empty probe range")
    `STLB_ASSERT_NOW(a_search_bound, state_reg == S_SEARCH, hi_reg <= n_reg, "range past count")
    `STLB_ASSERT_NOW(a_verify_index, state_reg == S_VERIFY, lo_reg < n_reg, "verify out of range")
    `STLB_ASSERT_NEXT(a_search_start, req_accept && req.kind == KIND_SEARCH,
        state_reg == S_SEARCH || state_reg == S_HOLD, "search did not start")

endmodule

/* rtl/sorted_table_lower_bound.sv */
// Top level of the sorted table lower-bound search block.
//
// Request channel (req_valid/req_stall): kind 0 writes key_value to table entry
// entry_index and gives no response; entries at or beyond the table depth are
// dropped. kind 1 searches the first entry_count entries (saturated at the
// depth) for the leftmost entry not below key_value.
// Response channel (rsp_valid/rsp_stall): one response per search with
// position and found.
// One key is read from the table RAM per cycle; a search takes up to p probes
// with p = ceil(log2(n + 1)) for n searched entries (11 at n = 1024), then the
// entry at the bound, if it lies inside the n entries, is read and checked for
// a hit, and then the response register is loaded.
// Loads are taken back to back. One request is worked at a time.
// The user writes entry_count through cfg_wr_en/cfg_wr_data only while the
// block is idle; the block itself does not enforce this.
// Reset clears entry_count and the control state; table contents stay
// undefined until loaded. A stalled response stays in its register; loads are
// still taken, and a finished search waits until the response register frees.
module sorted_table_lower_bound
    import stlb_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int KEY_WIDTH   = DEF_KEY_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [COUNT_W-1:0]  cfg_wr_data,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                kind,
    input  logic [INDEX_W-1:0]  entry_index,
    input  logic [KEY_IN_W-1:0] key_value,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [COUNT_W-1:0]  position,
    output logic                found
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    req_t               req;
    rsp_t               rsp;
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [KEY_WIDTH-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [KEY_WIDTH-1:0] ram_rd_data;

    assign req.kind        = kind;
    assign req.entry_index = entry_index;
    assign req.key_value   = key_value;
    assign position        = rsp.position;
    assign found           = rsp.found;

    stlb_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    stlb_ram #(
        .DATA_W (KEY_WIDTH),
        .DEPTH  (TABLE_DEPTH)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the sorted table lower-bound search block.
module tb;
    import stlb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 1024;
    localparam int GAP_MAX     = 17;
    localparam int SETTLE      = 20;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 60;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 56;

    class bound_scoreboard;
        logic [KEY_IN_W-1:0] table_keys[DEPTH];
        logic [COUNT_W-1:0]  entry_count;
        rsp_t                pending_bounds[$];
        int                  errors;

        function new();
            entry_count = '0;
            errors      = 0;
        endfunction

        function int searched_entries();
            return (entry_count > DEPTH) ? DEPTH : int'(entry_count);
        endfunction

        function void flag(string what, int want, int got);
            errors++;
            if (errors <= 10)
                $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
        endfunction

        function void note_request(logic k, logic [INDEX_W-1:0] idx, logic [KEY_IN_W-1:0] key);
            int   lo;
            int   hi;
            int   mid;
            int   n;
            rsp_t bound;
            if (k == KIND_LOAD) begin
                table_keys[idx] = key;
            end else begin
                n  = searched_entries();
                lo = 0;
                hi = n;
                while (lo < hi) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (table_keys[mid] < key)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                bound.position = COUNT_W'(lo);
                bound.found    = (lo < n) && (table_keys[lo] == key);
                pending_bounds.push_back(bound);
            end
        endfunction

        function void check_response(logic [COUNT_W-1:0] pos, logic hit);
            rsp_t want;
            if (pending_bounds.size() == 0) begin
                flag("unexpected response, position", -1, pos);
            end else begin
                want = pending_bounds.pop_front();
                if (pos !== want.position)
                    flag("position", want.position, pos);
                if (hit !== want.found)
                    flag("found", want.found, hit);
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [COUNT_W-1:0]  cfg_wr_data;
    logic                req_valid;
    logic                req_stall;
    logic                kind;
    logic [INDEX_W-1:0]  entry_index;
    logic [KEY_IN_W-1:0] key_value;
    logic                rsp_valid;
    logic                rsp_stall;
    logic [COUNT_W-1:0]  position;
    logic                found;

    bound_scoreboard sb;
    bit              fast_phase;
    int              responses_seen;
    int              cycle_count;

    sorted_table_lower_bound uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .kind       (kind),
        .entry_index(entry_index),
        .key_value  (key_value),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .position   (position),
        .found      (found)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // response side: random stalls, quiet stretches, one long hold-off
    initial
    begin : response_side
        int  gap;
        bit  quiet;
        rsp_stall = 1'b0;
        quiet     = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (responses_seen % 32 == 0)
                quiet = ($urandom_range(0, 2) == 0);
            gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
            if (responses_seen == HOLD_AT)
                gap = HOLD_CYCLES;
            @(negedge clk);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (rsp_valid !== 1'b1);
            sb.check_response(position, found);
            responses_seen++;
        end
    end

    function automatic int sender_gap();
        return fast_phase ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    task automatic send_request(input logic k, input logic [INDEX_W-1:0] idx,
                                input logic [KEY_IN_W-1:0] key, input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid   <= 1'b1;
        kind        <= k;
        entry_index <= idx;
        key_value   <= key;
        do @(posedge clk); while (req_stall !== 1'b0);
        sb.note_request(k, idx, key);
    endtask

    task automatic search(input logic [KEY_IN_W-1:0] key);
        send_request(KIND_SEARCH, INDEX_W'($urandom), key, sender_gap());
    endtask

    // drain, let any trailing load finish, then rewrite the count
    task automatic reconfigure_count(input logic [COUNT_W-1:0] value);
        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending_bounds.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sb.entry_count = value;
    endtask

    task automatic random_request();
        int                  n;
        int                  i;
        logic [KEY_IN_W-1:0] lo_key;
        logic [KEY_IN_W-1:0] hi_key;
        logic [KEY_IN_W-1:0] key;
        n = sb.searched_entries();
        if ($urandom_range(0, 9) < 3)
        begin
            if (n > 0 && $urandom_range(0, 19) != 0)
            begin
                i      = $urandom_range(0, n - 1);
                lo_key = (i == 0) ? '0 : sb.table_keys[i-1];
                hi_key = (i == DEPTH - 1) ? '1 : sb.table_keys[i+1];
                key    = (lo_key <= hi_key) ? $urandom_range(hi_key, lo_key)
                                            : sb.table_keys[i];
            end
            else
            begin
                i   = $urandom_range(0, DEPTH - 1);
                key = $urandom;
            end
            send_request(KIND_LOAD, INDEX_W'(i), key, sender_gap());
        end
        else
        begin
            key = $urandom;
            if (n > 0)
            begin
                i = $urandom_range(0, n - 1);
                case ($urandom_range(0, 3))
                    0, 1: key = sb.table_keys[i];
                    2:    key = sb.table_keys[i] + ($urandom_range(0, 1) ? 1 : -1);
                    default: ;
                endcase
            end
            search(key);
        end
    endtask

    initial
    begin : stimulus
        logic [KEY_IN_W-1:0] fill_key;
        logic [KEY_IN_W-1:0] saved_key;
        logic [COUNT_W-1:0]  phase_counts[8];
        sb             = new();
        responses_seen = 0;
        fast_phase     = 1'b0;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_data    = '0;
        req_valid      = 1'b0;
        kind           = KIND_LOAD;
        entry_index    = '0;
        key_value      = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table under the reset count
        search('0);
        search('1);
        send_request(KIND_LOAD, '1, '1, sender_gap());

        // fill the whole table ascending, with some duplicates
        fill_key = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == DEPTH - 1)
                fill_key = '1;
            else if (i > 0 && i % 97 != 0)
                fill_key = fill_key + $urandom_range(1, 4000000);
            send_request(KIND_LOAD, INDEX_W'(i), fill_key, 0);
        end

        // count above the depth saturates
        reconfigure_count('1);
        search('0);
        search('1);
        search(sb.table_keys[512]);
        search(sb.table_keys[512] + 1);
        search(sb.table_keys[300] - 1);
        search(sb.table_keys[97]);
        search($urandom);

        reconfigure_count(COUNT_W'(1));
        search('0);
        search('1);

        reconfigure_count(COUNT_W'(DEPTH));
        search('1);
        search(sb.table_keys[1]);

        // temporarily unsorted table
        reconfigure_count(COUNT_W'(16));
        saved_key = sb.table_keys[5];
        send_request(KIND_LOAD, INDEX_W'(5), '1, sender_gap());
        search(sb.table_keys[6]);
        search(sb.table_keys[4]);
        search('1);
        send_request(KIND_LOAD, INDEX_W'(5), saved_key, sender_gap());
        search(saved_key);

        phase_counts = '{COUNT_W'(0), COUNT_W'(2), COUNT_W'(DEPTH + 1), COUNT_W'(7),
                         COUNT_W'(DEPTH), COUNT_W'(1), COUNT_W'(DEPTH - 1),
                         COUNT_W'($urandom_range(3, 2047))};
        foreach (phase_counts[p])
        begin
            reconfigure_count(phase_counts[p]);
            fast_phase = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) random_request();
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.pending_bounds.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.pending_bounds.size() != 0)
            sb.flag("responses missing, count", 0, sb.pending_bounds.size());
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
